FILE: design/snt_pkg.sv
// snt_pkg: shared types and codes for the sorted neighbor table
// entry layout, opcodes, relation and link codes; used by the table and its checker
package snt_pkg;

   localparam int ADDR_W          = 48;
   localparam int OP_W            = 3;
   localparam int REL_W           = 2;
   localparam int LINK_W          = 2;
   localparam int MAX_ENTRIES_DEF = 16;

   localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_LINK = 3'd1;
   localparam logic [OP_W-1:0] OP_GET_LINK = 3'd2;
   localparam logic [OP_W-1:0] OP_MARK     = 3'd3;
   localparam logic [OP_W-1:0] OP_COUNT    = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

   localparam logic [REL_W-1:0]  REL_SUCCESSOR = 2'd0;
   localparam logic [LINK_W-1:0] LINK_NONE     = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [REL_W-1:0]  rel;
      logic [LINK_W-1:0] link;
      logic              topo;
   } entry_type;

endpackage

FILE: design/sorted_neighbor_table.sv
// sorted_neighbor_table: neighbor table kept sorted by address, one walk per operation
// depends on snt_pkg (entry layout, opcodes, codes)
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | opcode, neighbor_address, relation_in, link_in
//   rsp     | out       | rsp_valid/rsp_ready   | found .. table_full, one per req transfer
//
// one 48-bit comparator walks the entry memory one entry a cycle in S_SCAN (skipped for an
// empty table); S_POST then decides and S_DONE posts the result; an insert of a new address,
// a set link or a mark that hits adds a write in S_WRITE, and an insert that shifts first
// moves each entry from position up one place, read in S_SHIFT_RD and written in S_SHIFT_WR
// req_ready is high only while the sequencer is idle; a result still waiting in the output
// register holds the next operation in S_DONE until the result is taken
// reset clears the entry count and the handshakes; entries hold no reset value
module sorted_neighbor_table #(
   parameter int MAX_ENTRIES = snt_pkg::MAX_ENTRIES_DEF,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
   localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [snt_pkg::OP_W-1:0]    req_opcode,
   input  logic [snt_pkg::ADDR_W-1:0]  req_neighbor_address,
   input  logic [snt_pkg::REL_W-1:0]   req_relation_in,
   input  logic [snt_pkg::LINK_W-1:0]  req_link_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [CNT_W-1:0]            rsp_position,
   output logic [snt_pkg::LINK_W-1:0]  rsp_link_out,
   output logic [CNT_W-1:0]            rsp_match_count,
   output logic [CNT_W-1:0]            rsp_successor_count,
   output logic                        rsp_integrity_ok,
   output logic                        rsp_table_full
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_POST     = 3'd2;
   localparam logic [2:0] S_SHIFT_RD = 3'd3;
   localparam logic [2:0] S_SHIFT_WR = 3'd4;
   localparam logic [2:0] S_WRITE    = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   snt_pkg::entry_type entry_store [MAX_ENTRIES];
   snt_pkg::entry_type rd_data_ff;
   snt_pkg::entry_type wr_data;
   logic [IDX_W-1:0]   rd_idx, wr_idx;
   logic               mem_we;

   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           shift_ff, shift_in;
   logic [snt_pkg::OP_W-1:0]   op_ff, op_in;
   logic [snt_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [snt_pkg::REL_W-1:0]  rel_ff, rel_in;
   logic [snt_pkg::LINK_W-1:0] link_ff, link_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic [CNT_W-1:0]           match_ff, match_in;
   logic [CNT_W-1:0]           succ_ff, succ_in;
   logic                       hit_ff, hit_in;
   logic [snt_pkg::REL_W-1:0]  hit_rel_ff, hit_rel_in;
   logic [snt_pkg::LINK_W-1:0] hit_link_ff, hit_link_in;
   logic                       hit_topo_ff, hit_topo_in;
   logic                       bad_ff, bad_in;
   logic                       ins_ff, ins_in;
   logic                       full_ff, full_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]           rsp_pos_ff, rsp_pos_in;
   logic [snt_pkg::LINK_W-1:0] rsp_link_ff, rsp_link_in;
   logic [CNT_W-1:0]           rsp_match_ff, rsp_match_in;
   logic [CNT_W-1:0]           rsp_succ_ff, rsp_succ_in;
   logic                       rsp_integ_ff, rsp_integ_in;
   logic                       rsp_full_ff, rsp_full_in;

   // the shared compare unit
   logic addr_lt, addr_eq;
   assign addr_lt = rd_data_ff.addr < addr_ff;
   assign addr_eq = rd_data_ff.addr == addr_ff;

   logic new_succ;
   assign new_succ = ins_ff && (rel_ff == snt_pkg::REL_SUCCESSOR);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store[wr_idx] <= wr_data;
      end
      rd_data_ff <= entry_store[rd_idx];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      shift_in     = shift_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      rel_in       = rel_ff;
      link_in      = link_ff;
      pos_in       = pos_ff;
      match_in     = match_ff;
      succ_in      = succ_ff;
      hit_in       = hit_ff;
      hit_rel_in   = hit_rel_ff;
      hit_link_in  = hit_link_ff;
      hit_topo_in  = hit_topo_ff;
      bad_in       = bad_ff;
      ins_in       = ins_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_link_in  = rsp_link_ff;
      rsp_match_in = rsp_match_ff;
      rsp_succ_in  = rsp_succ_ff;
      rsp_integ_in = rsp_integ_ff;
      rsp_full_in  = rsp_full_ff;
      rd_idx       = idx_ff[IDX_W-1:0];
      wr_idx       = pos_ff[IDX_W-1:0];
      wr_data      = rd_data_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            rd_idx = '0;
            if (req_valid) begin
               op_in    = req_opcode;
               addr_in  = req_neighbor_address;
               rel_in   = req_relation_in;
               link_in  = req_link_in;
               idx_in   = '0;
               pos_in   = '0;
               match_in = '0;
               succ_in  = '0;
               hit_in   = 1'b0;
               bad_in   = 1'b0;
               ins_in   = 1'b0;
               full_in  = 1'b0;
               state_in = (count_ff == '0) ? S_POST : S_SCAN;
            end
         end
         S_SCAN: begin
            // rd_data_ff holds entry idx_ff, fetch the next one
            rd_idx = IDX_W'(idx_ff + 1'b1);
            if (addr_lt) begin
               pos_in = pos_ff + 1'b1;
            end
            if (addr_eq) begin
               hit_in      = 1'b1;
               hit_rel_in  = rd_data_ff.rel;
               hit_link_in = rd_data_ff.link;
               hit_topo_in = rd_data_ff.topo;
            end
            if (rd_data_ff.rel == rel_ff && rd_data_ff.link == link_ff) begin
               match_in = match_ff + 1'b1;
            end
            if (rd_data_ff.rel == snt_pkg::REL_SUCCESSOR) begin
               succ_in = succ_ff + 1'b1;
               // a marked entry has its topology after this operation
               if (!rd_data_ff.topo && !(op_ff == snt_pkg::OP_MARK && addr_eq)) begin
                  bad_in = 1'b1;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == count_ff) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            state_in = S_DONE;
            unique case (op_ff)
               snt_pkg::OP_INSERT: begin
                  if (!hit_ff) begin
                     if (count_ff == MAX_CNT) begin
                        full_in = 1'b1;
                     end else begin
                        ins_in = 1'b1;
                        if (pos_ff == count_ff) begin
                           state_in = S_WRITE;
                        end else begin
                           shift_in = count_ff - 1'b1;
                           state_in = S_SHIFT_RD;
                        end
                     end
                  end
               end
               snt_pkg::OP_SET_LINK, snt_pkg::OP_MARK: begin
                  if (hit_ff) begin
                     state_in = S_WRITE;
                  end
               end
               snt_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_SHIFT_RD: begin
            rd_idx   = shift_ff[IDX_W-1:0];
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            mem_we  = 1'b1;
            wr_idx  = IDX_W'(shift_ff + 1'b1);
            wr_data = rd_data_ff;
            if (shift_ff == pos_ff) begin
               state_in = S_WRITE;
            end else begin
               shift_in = shift_ff - 1'b1;
               state_in = S_SHIFT_RD;
            end
         end
         S_WRITE: begin
            mem_we       = 1'b1;
            wr_data.addr = addr_ff;
            if (ins_ff) begin
               wr_data.rel  = rel_ff;
               wr_data.link = link_ff;
               wr_data.topo = 1'b0;
               count_in     = count_ff + 1'b1;
            end else if (op_ff == snt_pkg::OP_SET_LINK) begin
               wr_data.rel  = hit_rel_ff;
               wr_data.link = link_ff;
               wr_data.topo = hit_topo_ff;
            end else begin
               wr_data.rel  = hit_rel_ff;
               wr_data.link = hit_link_ff;
               wr_data.topo = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_full_in  = full_ff;
               rsp_match_in = (op_ff == snt_pkg::OP_COUNT) ? match_ff : '0;
               if (op_ff == snt_pkg::OP_CLEAR) begin
                  rsp_pos_in   = '0;
                  rsp_link_in  = snt_pkg::LINK_NONE;
                  rsp_succ_in  = '0;
                  rsp_integ_in = 1'b0;
               end else begin
                  rsp_pos_in   = pos_ff;
                  rsp_succ_in  = succ_ff + CNT_W'(new_succ);
                  rsp_integ_in = (count_ff != '0) && !bad_ff && !new_succ;
                  if (ins_ff) begin
                     rsp_link_in = link_ff;
                  end else if (hit_ff) begin
                     rsp_link_in = (op_ff == snt_pkg::OP_SET_LINK) ? link_ff : hit_link_ff;
                  end else begin
                     rsp_link_in = snt_pkg::LINK_NONE;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      shift_ff     <= shift_in;
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      rel_ff       <= rel_in;
      link_ff      <= link_in;
      pos_ff       <= pos_in;
      match_ff     <= match_in;
      succ_ff      <= succ_in;
      hit_ff       <= hit_in;
      hit_rel_ff   <= hit_rel_in;
      hit_link_ff  <= hit_link_in;
      hit_topo_ff  <= hit_topo_in;
      bad_ff       <= bad_in;
      ins_ff       <= ins_in;
      full_ff      <= full_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_link_ff  <= rsp_link_in;
      rsp_match_ff <= rsp_match_in;
      rsp_succ_ff  <= rsp_succ_in;
      rsp_integ_ff <= rsp_integ_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_position        = rsp_pos_ff;
   assign rsp_link_out        = rsp_link_ff;
   assign rsp_match_count     = rsp_match_ff;
   assign rsp_successor_count = rsp_succ_ff;
   assign rsp_integrity_ok    = rsp_integ_ff;
   assign rsp_table_full      = rsp_full_ff;

endmodule

FILE: design/snt_checker.sv
// snt_checker: port-level assertions for the sorted neighbor table, with its bind
// depends on snt_pkg (link codes) and the ports of sorted_neighbor_table
module snt_checker #(
   parameter int MAX_ENTRIES = snt_pkg::MAX_ENTRIES_DEF,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [snt_pkg::OP_W-1:0]    req_opcode,
   input logic [snt_pkg::ADDR_W-1:0]  req_neighbor_address,
   input logic [snt_pkg::REL_W-1:0]   req_relation_in,
   input logic [snt_pkg::LINK_W-1:0]  req_link_in,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [CNT_W-1:0]            rsp_position,
   input logic [snt_pkg::LINK_W-1:0]  rsp_link_out,
   input logic [CNT_W-1:0]            rsp_match_count,
   input logic [CNT_W-1:0]            rsp_successor_count,
   input logic                        rsp_integrity_ok,
   input logic                        rsp_table_full
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   // a stalled result stays valid and holds its position, link, successor count and found flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) &&
         $stable(rsp_link_out) && $stable(rsp_successor_count) && $stable(rsp_found))
      else $error("stalled result changed");

   // req_ready is low in the cycle after an accepted request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted request");

   // a refused insert was a new address and leaves nothing to report a link for
   a_full_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |->
         !rsp_found && rsp_link_out == snt_pkg::LINK_NONE && rsp_position <= MAX_CNT)
      else $error("full flag with a present entry");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_successor_count <= MAX_CNT && rsp_match_count <= MAX_CNT)
      else $error("count beyond table size");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind sorted_neighbor_table snt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_snt_checker (.*);
